>>> rtl/assert_macros.svh
// Assertion macros shared by the UTF-16 to UTF-8 encoder RTL.
// Depends on nothing; pulled in by the top level with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/u16u8_pkg.sv
// Shared types, constants and the UTF-8 byte builder for the encoder.
// No dependencies; used by the interfaces and all encoder modules.
package u16u8_pkg;

   localparam int UNIT_W         = 16;
   localparam int CAP_W          = 21;
   localparam int CP_W           = 21;
   localparam int BYTE_W         = 8;
   localparam int LEN_W          = 20;
   localparam int NB_W           = 3;
   localparam int COUNT_BITS_DEF = 20;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [CAP_W-1:0] CAP_RESET   = 21'd1024;
   localparam logic [CP_W-1:0]  REPLACEMENT = 21'h00FFFD;
   localparam logic [CP_W-1:0]  PAIR_BASE   = 21'h010000;
   localparam logic [5:0]       SUR_HIGH_TAG = 6'b110110;
   localparam logic [5:0]       SUR_LOW_TAG  = 6'b110111;
   localparam logic [NB_W-1:0]  REPL_BYTES   = 3'd3;

   // One queue entry: everything one item sends out
   typedef struct packed {
      logic             repl_en;   // held surrogate goes out as U+FFFD first
      logic [CP_W-1:0]  cp;        // main character
      logic [NB_W-1:0]  nbytes;    // its byte count, zero if not sent
      logic             term;      // close the string
      logic [LEN_W-1:0] tlen;      // byte count carried by the terminator
   } entry_type;

   typedef struct packed {
      logic      avail;
      entry_type entry;
   } q_head_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_REPL,
      BK_CHAR,
      BK_TERM
   } back_state_type;

   // Byte idx (from the lead byte) of the UTF-8 form of cp, nbytes long
   function automatic logic [BYTE_W-1:0] utf8_byte(
      input logic [CP_W-1:0] cp,
      input logic [NB_W-1:0] nbytes,
      input logic [1:0]      idx
   );
      logic [BYTE_W-1:0] b;
      b = '0;
      unique case (nbytes)
         3'd2: begin
            b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         end
         3'd3: begin
            unique case (idx)
               2'd0:    b = {4'b1110, cp[15:12]};
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         3'd4: begin
            unique case (idx)
               2'd0:    b = {5'b11110, cp[20:18]};
               2'd1:    b = {2'b10, cp[17:12]};
               2'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            b = cp[7:0];
         end
      endcase
      return b;
   endfunction

endpackage

>>> rtl/u16u8_if.sv
// Channel interfaces of the encoder: code units in, bytes out, capacity write.
// Depends on u16u8_pkg for field widths.
interface u16u8_req_if;
   logic                        valid;
   logic                        ready;
   logic [u16u8_pkg::UNIT_W-1:0] code_unit;
   logic                        unit_present;
   logic                        last_unit;
   modport source(output valid, code_unit, unit_present, last_unit, input ready);
   modport sink(input valid, code_unit, unit_present, last_unit, output ready);
endinterface

interface u16u8_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [u16u8_pkg::BYTE_W-1:0] data_byte;
   logic                         is_terminator;
   logic [u16u8_pkg::LEN_W-1:0]  total_length;
   logic                         last_of_run;
   modport source(output valid, data_byte, is_terminator, total_length, last_of_run,
                  input ready);
   modport sink(input valid, data_byte, is_terminator, total_length, last_of_run,
                output ready);
endinterface

interface u16u8_csr_if;
   logic                        valid;
   logic                        ready;
   logic [u16u8_pkg::CAP_W-1:0] buffer_capacity;
   modport source(output valid, buffer_capacity, input ready);
   modport sink(input valid, buffer_capacity, output ready);
endinterface

>>> rtl/u16u8_front.sv
// Front end: accepts code units, pairs surrogates, checks capacity, keeps counts.
// Depends on u16u8_pkg and u16u8_if; feeds u16u8_queue.
module u16u8_front #(
   parameter int COUNT_BITS = u16u8_pkg::COUNT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   u16u8_csr_if.sink            csr_ch,
   u16u8_req_if.sink            req_ch,
   input  logic                 q_full,
   output logic                 push,
   output u16u8_pkg::entry_type push_entry
);

   localparam int SUMW = (COUNT_BITS + 1 > u16u8_pkg::CAP_W) ? COUNT_BITS + 1
                                                             : u16u8_pkg::CAP_W;
   localparam int LW   = (COUNT_BITS > u16u8_pkg::LEN_W) ? COUNT_BITS : u16u8_pkg::LEN_W;
   localparam logic [SUMW-1:0] CAP_LIMIT = SUMW'(1) << COUNT_BITS;

   logic [u16u8_pkg::CAP_W-1:0] cap_ff;
   logic                        pending_ff, pending_in;
   logic [9:0]                  held_ff, held_in;
   logic [COUNT_BITS-1:0]       bw_ff, bw_in;
   logic                        stop_ff, stop_in;

   logic                            accept, present, last, is_high, is_low;
   logic                            pair, repl_req, hold_new, main_req;
   logic [u16u8_pkg::CP_W-1:0]      pair_cp, cp_main;
   logic [u16u8_pkg::NB_W-1:0]      nb, nb_plus;
   logic [SUMW-1:0]                 cap_ext, cap_eff, bw_ext, s_a, s_b, s_ab, s_main, bw_new;
   logic                            fit_a, stop_a, fit_b, stop_b;
   logic [LW-1:0]                   tl_ext;

   // Capacity register, writes taken at any time
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= u16u8_pkg::CAP_RESET;
      end else if (csr_ch.valid) begin
         cap_ff <= csr_ch.buffer_capacity;
      end
   end

   // Classify the unit
   assign req_ch.ready = !q_full;
   assign accept  = req_ch.valid && req_ch.ready;
   assign present = req_ch.unit_present;
   assign last    = req_ch.last_unit;
   assign is_high = (req_ch.code_unit[15:10] == u16u8_pkg::SUR_HIGH_TAG);
   assign is_low  = (req_ch.code_unit[15:10] == u16u8_pkg::SUR_LOW_TAG);

   assign pair     = present && pending_ff && is_low;
   assign repl_req = pending_ff && !pair && (present || last);
   assign hold_new = present && !pair && is_high && !last;
   assign main_req = present && !hold_new;

   assign pair_cp = u16u8_pkg::PAIR_BASE + {1'b0, held_ff, req_ch.code_unit[9:0]};

   always_comb begin
      if (pair) begin
         cp_main = pair_cp;
      end else if (is_high || is_low) begin
         cp_main = u16u8_pkg::REPLACEMENT;
      end else begin
         cp_main = {5'd0, req_ch.code_unit};
      end
   end

   // UTF-8 length of the main character
   always_comb begin
      priority if (cp_main < 21'h80) begin
         nb = 3'd1;
      end else if (cp_main < 21'h800) begin
         nb = 3'd2;
      end else if (cp_main < 21'h10000) begin
         nb = 3'd3;
      end else begin
         nb = 3'd4;
      end
   end

   // Capacity checks, one byte kept back for the terminator
   assign cap_ext = SUMW'(cap_ff);
   assign cap_eff = (cap_ext < CAP_LIMIT) ? cap_ext : CAP_LIMIT;
   assign bw_ext  = SUMW'(bw_ff);
   assign nb_plus = nb + u16u8_pkg::REPL_BYTES;
   assign s_a     = bw_ext + SUMW'(u16u8_pkg::REPL_BYTES);
   assign s_b     = bw_ext + SUMW'(nb);
   assign s_ab    = bw_ext + SUMW'(nb_plus);

   assign fit_a  = repl_req && !stop_ff && (s_a < cap_eff);
   assign stop_a = stop_ff || (repl_req && !fit_a);
   assign s_main = fit_a ? s_ab : s_b;
   assign fit_b  = main_req && !stop_a && (s_main < cap_eff);
   assign stop_b = stop_a || (main_req && !fit_b);

   always_comb begin
      if (fit_b) begin
         bw_new = s_main;
      end else if (fit_a) begin
         bw_new = s_a;
      end else begin
         bw_new = bw_ext;
      end
   end

   // Queue entry for this item
   assign tl_ext = LW'(COUNT_BITS'(bw_new));
   assign push   = accept && (fit_a || fit_b || last);

   always_comb begin
      push_entry.repl_en = fit_a;
      push_entry.cp      = cp_main;
      push_entry.nbytes  = fit_b ? nb : 3'd0;
      push_entry.term    = last;
      push_entry.tlen    = tl_ext[u16u8_pkg::LEN_W-1:0];
   end

   // String state, cleared by the end of each string
   always_comb begin
      pending_in = pending_ff;
      held_in    = held_ff;
      bw_in      = bw_ff;
      stop_in    = stop_ff;
      if (accept) begin
         if (last) begin
            pending_in = 1'b0;
            bw_in      = '0;
            stop_in    = 1'b0;
         end else if (present) begin
            pending_in = hold_new;
            bw_in      = COUNT_BITS'(bw_new);
            stop_in    = stop_b;
            if (hold_new) begin
               held_in = req_ch.code_unit[9:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         held_ff    <= '0;
         bw_ff      <= '0;
         stop_ff    <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         held_ff    <= held_in;
         bw_ff      <= bw_in;
         stop_ff    <= stop_in;
      end
   end

endmodule

>>> rtl/u16u8_queue.sv
// Small FIFO of work entries between the front and back ends.
// Depends on u16u8_pkg for the entry type.
module u16u8_queue #(
   parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  u16u8_pkg::entry_type  push_entry,
   input  logic                  pop,
   output logic                  full,
   output u16u8_pkg::q_head_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   u16u8_pkg::entry_type slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head.avail = (count_ff != '0);
   assign head.entry = slots_ff[rd_ptr_ff];
   assign do_pop     = pop && head.avail;

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/u16u8_back.sv
// Back end: walks one queue entry out as UTF-8 bytes and the terminator.
// Depends on u16u8_pkg and u16u8_if; drains u16u8_queue.
module u16u8_back (
   input  logic                  clock,
   input  logic                  reset,
   input  u16u8_pkg::q_head_type head,
   output logic                  pop,
   u16u8_rsp_if.source           rsp_ch
);

   u16u8_pkg::back_state_type state_ff, state_in;
   u16u8_pkg::entry_type      entry_ff;
   logic [1:0]                idx_ff, idx_in;

   logic                           rsp_valid_ff;
   logic [u16u8_pkg::BYTE_W-1:0]   byte_ff;
   logic                           term_ff;
   logic [u16u8_pkg::LEN_W-1:0]    len_ff;
   logic                           last_ff;

   logic                           can_emit, step_last, ent_last;
   logic [u16u8_pkg::BYTE_W-1:0]   cur_byte;
   logic [1:0]                     char_end;

   assign char_end = 2'(entry_ff.nbytes - 3'd1);
   assign can_emit = (state_ff != u16u8_pkg::BK_IDLE) && (!rsp_valid_ff || rsp_ch.ready);

   // Current byte and end flags
   always_comb begin
      cur_byte  = '0;
      step_last = 1'b0;
      ent_last  = 1'b0;
      unique case (state_ff)
         u16u8_pkg::BK_REPL: begin
            cur_byte  = u16u8_pkg::utf8_byte(u16u8_pkg::REPLACEMENT,
                                             u16u8_pkg::REPL_BYTES, idx_ff);
            step_last = (idx_ff == 2'd2);
            ent_last  = step_last && (entry_ff.nbytes == 3'd0) && !entry_ff.term;
         end
         u16u8_pkg::BK_CHAR: begin
            cur_byte  = u16u8_pkg::utf8_byte(entry_ff.cp, entry_ff.nbytes, idx_ff);
            step_last = (idx_ff == char_end);
            ent_last  = step_last && !entry_ff.term;
         end
         u16u8_pkg::BK_TERM: begin
            step_last = 1'b1;
            ent_last  = 1'b1;
         end
         default: begin
            cur_byte = '0;
         end
      endcase
      pop = head.avail && ((state_ff == u16u8_pkg::BK_IDLE) || (can_emit && ent_last));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      if (pop) begin
         idx_in = '0;
         if (head.entry.repl_en) begin
            state_in = u16u8_pkg::BK_REPL;
         end else if (head.entry.nbytes != 3'd0) begin
            state_in = u16u8_pkg::BK_CHAR;
         end else begin
            state_in = u16u8_pkg::BK_TERM;
         end
      end else if (can_emit && step_last) begin
         idx_in = '0;
         unique case (state_ff)
            u16u8_pkg::BK_REPL: begin
               if (entry_ff.nbytes != 3'd0) begin
                  state_in = u16u8_pkg::BK_CHAR;
               end else if (entry_ff.term) begin
                  state_in = u16u8_pkg::BK_TERM;
               end else begin
                  state_in = u16u8_pkg::BK_IDLE;
               end
            end
            u16u8_pkg::BK_CHAR: begin
               state_in = entry_ff.term ? u16u8_pkg::BK_TERM : u16u8_pkg::BK_IDLE;
            end
            default: begin
               state_in = u16u8_pkg::BK_IDLE;
            end
         endcase
      end else if (can_emit) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= u16u8_pkg::BK_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // Hold the entry being sent
   always_ff @(posedge clock) begin
      if (pop) begin
         entry_ff <= head.entry;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (can_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (can_emit) begin
         byte_ff <= cur_byte;
         term_ff <= (state_ff == u16u8_pkg::BK_TERM);
         len_ff  <= (state_ff == u16u8_pkg::BK_TERM) ? entry_ff.tlen : '0;
         last_ff <= ent_last;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.data_byte     = byte_ff;
   assign rsp_ch.is_terminator = term_ff;
   assign rsp_ch.total_length  = len_ff;
   assign rsp_ch.last_of_run   = last_ff;

endmodule

>>> rtl/utf16_to_utf8_encoder.sv
// UTF-16 to UTF-8 encoder. A code unit is taken every cycle while the work
// queue (QUEUE_DEPTH entries) has room; the output sends one byte per cycle
// while the receiver is ready, so an item costs as many output slots as the results
// it causes, zero to seven. The byte-wide output register sets the sustained rate.
// Results pass through the work queue, the entry register and the output register. No clearing pass after reset.
// Depends on u16u8_pkg, u16u8_if, u16u8_front, u16u8_queue, u16u8_back.
`include "assert_macros.svh"

module utf16_to_utf8_encoder #(
   parameter int COUNT_BITS  = u16u8_pkg::COUNT_BITS_DEF,
   parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
   input logic         clock,
   input logic         reset,
   u16u8_csr_if.sink   csr_ch,
   u16u8_req_if.sink   req_ch,
   u16u8_rsp_if.source rsp_ch
);

   logic                  q_full, push, pop;
   u16u8_pkg::entry_type  push_entry;
   u16u8_pkg::q_head_type head;

   // Accept and classify units
   u16u8_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_ch     (csr_ch),
      .req_ch     (req_ch),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Buffer work between the two ends
   u16u8_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .head       (head)
   );

   // Send bytes
   u16u8_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

   `ASSERT_IMPLIES(a_last_pushes, clock, reset,
      req_ch.valid && req_ch.ready && req_ch.last_unit, push,
      "string end did not queue a terminator")
   `ASSERT_IMPLIES(a_term_ends_run, clock, reset,
      rsp_ch.valid && rsp_ch.is_terminator,
      rsp_ch.last_of_run && (rsp_ch.data_byte == '0),
      "terminator is not a closing zero byte")
   `ASSERT_IMPLIES(a_data_len_zero, clock, reset,
      rsp_ch.valid && !rsp_ch.is_terminator, rsp_ch.total_length == '0,
      "data byte carries a length")
   `ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_ch.valid && !rsp_ch.ready,
      rsp_ch.valid && $stable(rsp_ch.data_byte) && $stable(rsp_ch.is_terminator)
         && $stable(rsp_ch.total_length) && $stable(rsp_ch.last_of_run),
      "result changed while stalled")

endmodule

>>> tb/sv/utf16_to_utf8_encoder_tb.sv
`timescale 1ns / 100ps
// Testbench for utf16_to_utf8_encoder: feeds UTF-16 strings, predicts every UTF-8
// byte and terminator, and checks each output item in order against the prediction.
// Depends on u16u8_pkg, the u16u8 channel interfaces and the encoder top level.
module utf16_to_utf8_encoder_tb;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 10;
   localparam int STALL_LIMIT   = 3000;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [u16u8_pkg::CAP_W-1:0] CAP_CEILING  = 21'h100000;
   localparam logic [u16u8_pkg::CAP_W-1:0] CAP_ALL_ONES = 21'h1FFFFF;

   typedef struct packed {
      logic [u16u8_pkg::UNIT_W-1:0] unit;
      logic                         present;
      logic                         last;
   } unit_item_type;

   typedef struct packed {
      logic [u16u8_pkg::BYTE_W-1:0] data;
      logic                         term;
      logic [u16u8_pkg::LEN_W-1:0]  len;
      logic                         last;
   } out_byte_type;

   typedef enum logic [1:0] {
      PACE_FULL,
      PACE_COIN,
      PACE_THIRD
   } pace_mode_type;

   logic clock = 1'b0;
   logic reset;

   u16u8_csr_if csr_bus();
   u16u8_req_if req_bus();
   u16u8_rsp_if rsp_bus();

   utf16_to_utf8_encoder u_dut (
      .clock (clock),
      .reset (reset),
      .csr_ch(csr_bus),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus)
   );

   // Stimulus and scoreboard bookkeeping
   unit_item_type pending_units[$];
   out_byte_type  expected_bytes[$];
   out_byte_type  run_bytes[$];
   int   units_queued  = 0;
   int   units_taken   = 0;
   int   error_count   = 0;
   int   idle_cycles   = 0;
   int   hold_requests = 0;
   int   hold_served   = 0;
   int   hold_left     = 0;
   int   burst_left    = 0;
   int   gap_left      = 0;
   int   mode_left     = 0;
   int   pace_tick     = 0;
   pace_mode_type pace_mode = PACE_FULL;
   logic req_taken     = 1'b0;

   // Encoder state as the block should hold it
   logic [u16u8_pkg::CAP_W-1:0] cap_setting = u16u8_pkg::CAP_RESET;
   logic                        high_held   = 1'b0;
   logic [9:0]                  held_bits   = '0;
   logic [u16u8_pkg::LEN_W-1:0] byte_count  = '0;
   logic                        out_stopped = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   function automatic void put_byte(input logic [u16u8_pkg::BYTE_W-1:0] b, input logic term,
                                    input logic [u16u8_pkg::LEN_W-1:0] len);
      out_byte_type o;
      o.data = b;
      o.term = term;
      o.len  = len;
      o.last = 1'b0;
      run_bytes.push_back(o);
   endfunction

   // Encode one scalar value, or stop the string if it does not fit whole
   function automatic void emit_scalar(input logic [u16u8_pkg::CP_W-1:0] cp);
      logic [u16u8_pkg::CP_W:0] room;
      logic [u16u8_pkg::CP_W:0] need;
      if (out_stopped) return;
      room = (cap_setting > CAP_CEILING) ? {1'b0, CAP_CEILING} : {1'b0, cap_setting};
      if (cp < 'h80) need = 1;
      else if (cp < 'h800) need = 2;
      else if (cp < 'h10000) need = 3;
      else need = 4;
      if ({2'b00, byte_count} + need >= room) begin
         out_stopped = 1'b1;
         return;
      end
      case (need)
         1: begin
            put_byte(cp[7:0], 1'b0, '0);
         end
         2: begin
            put_byte({3'b110, cp[10:6]}, 1'b0, '0);
            put_byte({2'b10, cp[5:0]}, 1'b0, '0);
         end
         3: begin
            put_byte({4'b1110, cp[15:12]}, 1'b0, '0);
            put_byte({2'b10, cp[11:6]}, 1'b0, '0);
            put_byte({2'b10, cp[5:0]}, 1'b0, '0);
         end
         default: begin
            put_byte({5'b11110, cp[20:18]}, 1'b0, '0);
            put_byte({2'b10, cp[17:12]}, 1'b0, '0);
            put_byte({2'b10, cp[11:6]}, 1'b0, '0);
            put_byte({2'b10, cp[5:0]}, 1'b0, '0);
         end
      endcase
      byte_count = byte_count + need[u16u8_pkg::LEN_W-1:0];
   endfunction

   // Work out the bytes one accepted code unit causes and append them
   function automatic void predict_bytes(input unit_item_type it);
      logic         is_high;
      logic         is_low;
      out_byte_type o;
      run_bytes.delete();
      is_high = (it.unit[15:10] == u16u8_pkg::SUR_HIGH_TAG);
      is_low  = (it.unit[15:10] == u16u8_pkg::SUR_LOW_TAG);
      if (it.present) begin
         if (high_held && is_low) begin
            high_held = 1'b0;
            emit_scalar(u16u8_pkg::PAIR_BASE + {1'b0, held_bits, it.unit[9:0]});
         end else begin
            // an unpaired held surrogate goes out as the replacement first
            if (high_held) begin
               high_held = 1'b0;
               emit_scalar(u16u8_pkg::REPLACEMENT);
            end
            if (is_high && !it.last) begin
               high_held = 1'b1;
               held_bits = it.unit[9:0];
            end else if (is_high || is_low) begin
               emit_scalar(u16u8_pkg::REPLACEMENT);
            end else begin
               emit_scalar({5'd0, it.unit});
            end
         end
      end
      if (it.last) begin
         if (high_held) begin
            high_held = 1'b0;
            emit_scalar(u16u8_pkg::REPLACEMENT);
         end
         put_byte('0, 1'b1, byte_count);
         byte_count  = '0;
         out_stopped = 1'b0;
      end
      foreach (run_bytes[i]) begin
         o      = run_bytes[i];
         o.last = (i == run_bytes.size() - 1);
         expected_bytes.push_back(o);
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endfunction

   // Sample all three channels, predict, compare, and watch for a hang
   always @(posedge clock) begin : watch
      out_byte_type  want;
      unit_item_type got_unit;
      logic          fired;
      fired = 1'b0;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            cap_setting = csr_bus.buffer_capacity;
            fired = 1'b1;
         end
         if (req_bus.valid && req_bus.ready) begin
            got_unit.unit    = req_bus.code_unit;
            got_unit.present = req_bus.unit_present;
            got_unit.last    = req_bus.last_unit;
            predict_bytes(got_unit);
            units_taken++;
            fired = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            fired = 1'b1;
            if (expected_bytes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected item: byte 0x%0h term %0b len %0d last %0b", $time,
                        rsp_bus.data_byte, rsp_bus.is_terminator, rsp_bus.total_length,
                        rsp_bus.last_of_run);
            end else begin
               want = expected_bytes.pop_front();
               check_field("data_byte", 32'(want.data), 32'(rsp_bus.data_byte));
               check_field("is_terminator", 32'(want.term), 32'(rsp_bus.is_terminator));
               check_field("total_length", 32'(want.len), 32'(rsp_bus.total_length));
               check_field("last_of_run", 32'(want.last), 32'(rsp_bus.last_of_run));
            end
         end
      end
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      idle_cycles = fired ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("utf16_to_utf8_encoder_tb NOT OK");
         $finish;
      end
   end

   // Drive code units in bursts with random gaps
   always @(negedge clock) begin : drive
      unit_item_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_units.size() != 0) begin
            nxt = pending_units.pop_front();
            req_bus.code_unit    <= nxt.unit;
            req_bus.unit_present <= nxt.present;
            req_bus.last_unit    <= nxt.last;
            req_bus.valid        <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Pace the output side; a requested long hold takes priority
   always @(negedge clock) begin : sink_pace
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            pace_mode = pace_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         pace_tick++;
         case (pace_mode)
            PACE_FULL: rsp_bus.ready <= 1'b1;
            PACE_COIN: rsp_bus.ready <= 1'($urandom_range(0, 1));
            default:   rsp_bus.ready <= (pace_tick % 3 == 0);
         endcase
      end
   end

   function automatic void queue_unit(input logic [u16u8_pkg::UNIT_W-1:0] u,
                                      input logic present, input logic last);
      unit_item_type it;
      it.unit    = u;
      it.present = present;
      it.last    = last;
      pending_units.push_back(it);
      units_queued++;
   endfunction

   // Build one random string, mostly well-formed text; return its item count
   function automatic int queue_string();
      unit_item_type str[$];
      unit_item_type it;
      int            len;
      int            pick;
      logic [9:0]    low_bits;
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
         pick       = $urandom_range(0, 99);
         low_bits   = 10'($urandom);
         it.present = 1'b1;
         it.last    = 1'b0;
         if (pick < 30) begin
            it.unit = 16'($urandom_range(0, 'h7F));
         end else if (pick < 45) begin
            it.unit = 16'($urandom_range('h80, 'h7FF));
         end else if (pick < 65) begin
            // three-byte range; push surrogate values up out of the reserved block
            it.unit = 16'($urandom_range('h800, 'hFFFF));
            if (it.unit[15:11] == 5'b11011) it.unit[13] = 1'b1;
         end else if (pick < 85) begin
            it.unit = {u16u8_pkg::SUR_HIGH_TAG, low_bits};
            str.push_back(it);
            low_bits = 10'($urandom);
            it.unit  = {u16u8_pkg::SUR_LOW_TAG, low_bits};
         end else if (pick < 90) begin
            it.unit = {u16u8_pkg::SUR_HIGH_TAG, low_bits};
         end else if (pick < 95) begin
            it.unit = {u16u8_pkg::SUR_LOW_TAG, low_bits};
         end else begin
            it.unit    = 16'($urandom);
            it.present = 1'b0;
         end
         str.push_back(it);
      end
      if ($urandom_range(0, 5) == 0) begin
         it.unit    = 16'($urandom);
         it.present = 1'b0;
         it.last    = 1'b1;
         str.push_back(it);
      end else begin
         it      = str.pop_back();
         it.last = 1'b1;
         str.push_back(it);
      end
      foreach (str[i]) queue_unit(str[i].unit, str[i].present, str[i].last);
      return str.size();
   endfunction

   task automatic write_capacity(input logic [u16u8_pkg::CAP_W-1:0] value);
      @(negedge clock);
      csr_bus.valid           <= 1'b1;
      csr_bus.buffer_capacity <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Hold until every queued item is taken and every byte has come back
   task automatic wait_drained();
      while (units_taken != units_queued || expected_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input logic [u16u8_pkg::CAP_W-1:0] cap, input int n_units,
                            input bit long_hold, input bit mid_pause);
      int done;
      bit paused;
      done   = 0;
      paused = 1'b0;
      wait_drained();
      write_capacity(cap);
      @(posedge clock);
      if (long_hold) hold_requests++;
      while (done < n_units) begin
         if (mid_pause && !paused && done >= n_units / 2) begin
            paused = 1'b1;
            wait_drained();
            @(posedge clock);
         end
         done += queue_string();
      end
   endtask

   initial begin
      reset                   = 1'b1;
      csr_bus.valid           = 1'b0;
      csr_bus.buffer_capacity = '0;
      req_bus.valid           = 1'b0;
      req_bus.code_unit       = '0;
      req_bus.unit_present    = 1'b0;
      req_bus.last_unit       = 1'b0;
      rsp_bus.ready           = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed strings at the reset capacity: encoding boundaries
      queue_unit(16'h0000, 1'b1, 1'b0);
      queue_unit(16'h007F, 1'b1, 1'b0);
      queue_unit(16'h0080, 1'b1, 1'b0);
      queue_unit(16'h07FF, 1'b1, 1'b0);
      queue_unit(16'h0800, 1'b1, 1'b0);
      queue_unit(16'hD7FF, 1'b1, 1'b0);
      queue_unit(16'hE000, 1'b1, 1'b0);
      queue_unit(16'hFFFF, 1'b1, 1'b1);
      // lowest and highest surrogate pairs
      queue_unit(16'hD800, 1'b1, 1'b0);
      queue_unit(16'hDC00, 1'b1, 1'b0);
      queue_unit(16'hDBFF, 1'b1, 1'b0);
      queue_unit(16'hDFFF, 1'b1, 1'b0);
      queue_unit(16'h00A9, 1'b1, 1'b1);
      // held high before plain text, lone low, high-high-low, skip item, high on last
      queue_unit(16'hD83D, 1'b1, 1'b0);
      queue_unit(16'h0041, 1'b1, 1'b0);
      queue_unit(16'hDC00, 1'b1, 1'b0);
      queue_unit(16'hD800, 1'b1, 1'b0);
      queue_unit(16'hD801, 1'b1, 1'b0);
      queue_unit(16'hDE00, 1'b1, 1'b0);
      queue_unit(16'hFFFF, 1'b0, 1'b0);
      queue_unit(16'hD800, 1'b1, 1'b1);
      // held high closed by a bare end marker, then an empty string
      queue_unit(16'hD801, 1'b1, 1'b0);
      queue_unit(16'hA5A5, 1'b0, 1'b1);
      queue_unit(16'h0000, 1'b0, 1'b1);
      // pair completed on the last unit, held high replaced before a last high
      queue_unit(16'hD800, 1'b1, 1'b0);
      queue_unit(16'hDC01, 1'b1, 1'b1);
      queue_unit(16'hDBFF, 1'b1, 1'b0);
      queue_unit(16'hD800, 1'b1, 1'b1);

      // Random strings across capacity settings, tight ones first
      run_phase('0, 14, 1'b0, 1'b0);
      run_phase(21'd1, 14, 1'b0, 1'b0);
      run_phase(21'd2, 12, 1'b0, 1'b0);
      run_phase(21'd4, 14, 1'b0, 1'b0);
      run_phase(21'd7, 16, 1'b0, 1'b1);
      run_phase(21'd12, 16, 1'b0, 1'b0);
      run_phase(CAP_ALL_ONES, 20, 1'b1, 1'b0);
      run_phase(CAP_CEILING, 14, 1'b0, 1'b0);
      run_phase(21'($urandom_range(3, 40)), 14, 1'b0, 1'b0);
      run_phase(u16u8_pkg::CAP_RESET, 14, 1'b0, 1'b0);

      wait_drained();
      if (error_count == 0) begin
         $display("utf16_to_utf8_encoder_tb OK");
      end else begin
         $display("utf16_to_utf8_encoder_tb NOT OK");
      end
      $finish;
   end

endmodule
